FILE: src/ppc_pkg.sv
// Shared types and constants for the point-in-polygon crossing test.
// No dependencies; used by ppc_divider and point_in_polygon_crossing.
package ppc_pkg;

  // Vertex counter saturates at three (a polygon needs at least three vertices)
  localparam int unsigned SEEN_WIDTH = 2;
  localparam logic [SEEN_WIDTH-1:0] SEEN_SAT = 2'd3;
  localparam logic [SEEN_WIDTH-1:0] SEEN_MIN_POLY = 2'd2;

  // Control from the sequencer to the serial divider
  typedef struct packed {
    logic start;
  } ppc_div_ctrl_t;

  // Status from the serial divider back to the sequencer
  typedef struct packed {
    logic done;
  } ppc_div_stat_t;

endpackage

FILE: src/point_in_polygon_crossing.sv
// Point-in-polygon crossing test, top level with the edge sequencer.
// Depends on ppc_pkg and ppc_divider.
//
// Vertices of a polygon arrive one item at a time; the test point is taken
// from the first vertex. Each item is worked on alone and in_ready is low
// until it is finished. The first vertex of a polygon tests no edge. Every
// further vertex tests one edge, and the last vertex tests a second (closing)
// edge. An edge whose ends are on the same side of the point's y, or both
// left or both right of the point's x, is settled without the divider; an
// edge that needs its x intercept goes through the serial divider that
// produces one quotient bit of the 2*COORD_WIDTH+2 bit
// product per cycle. One multiply feeds that divider once per edge. A result
// is given on every last vertex; it sits in an output register, and the
// block accepts new items while it waits to be taken. A further last vertex
// holds the block in its final step until that register is free.
module point_in_polygon_crossing #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          inside_res,
  output logic                          too_few
);

  localparam int DW = COORD_WIDTH + 1;      // difference width
  localparam int PW = 2 * DW;               // product width

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_WRAP = 3'd6;

  logic [2:0] state;

  // Polygon state
  logic signed [COORD_WIDTH-1:0] held_point_x, held_point_y;
  logic signed [COORD_WIDTH-1:0] first_vx, first_vy;
  logic signed [COORD_WIDTH-1:0] prev_vx, prev_vy;
  logic signed [COORD_WIDTH-1:0] cur_vx, cur_vy;
  logic                          last_r;
  logic                          closing;
  logic [ppc_pkg::SEEN_WIDTH-1:0] seen_count;
  logic                          parity;

  // Edge operands
  logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1;
  logic                          yf0, yf1, xf0, xf1;
  logic signed [DW-1:0]          a_diff, b_diff, d_diff, r_diff;
  logic [DW-1:0]                 a_mag, b_mag, d_mag;
  logic signed [DW-1:0]          r_val;
  logic                          neg;

  // Intercept datapath
  logic [PW-1:0]                 mul_res;
  logic [PW-1:0]                 quotient;
  logic signed [PW:0]            q_signed;
  logic signed [PW:0]            r_ext;
  logic                          cross_hit;
  ppc_pkg::ppc_div_ctrl_t        div_ctrl;
  ppc_pkg::ppc_div_stat_t        div_stat;

  assign in_ready = (state == S_IDLE);

  // Edge ends: (prev -> cur) or the closing (cur -> first)
  assign x0 = closing ? cur_vx   : prev_vx;
  assign y0 = closing ? cur_vy   : prev_vy;
  assign x1 = closing ? first_vx : cur_vx;
  assign y1 = closing ? first_vy : cur_vy;

  assign yf0 = y0 >= held_point_y;
  assign yf1 = y1 >= held_point_y;
  assign xf0 = x0 >= held_point_x;
  assign xf1 = x1 >= held_point_x;

  // Differences at one extra bit so nothing wraps
  assign a_diff = DW'(y1) - DW'(held_point_y);
  assign b_diff = DW'(x0) - DW'(x1);
  assign d_diff = DW'(y0) - DW'(y1);
  assign r_diff = DW'(x1) - DW'(held_point_x);

  // Product of magnitudes, registered inside the divider
  assign mul_res = PW'(a_mag) * PW'(b_mag);

  // Signed quotient against x1 - px
  assign q_signed  = neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
  assign r_ext     = (PW+1)'(r_val);
  assign cross_hit = r_ext >= q_signed;

  assign div_ctrl.start = (state == S_MUL);

  ppc_divider #(
    .NUM_WIDTH(PW),
    .DEN_WIDTH(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (mul_res),
    .divisor  (d_mag),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seen_count <= '0;
      parity     <= 1'b0;
      out_valid  <= 1'b0;
      closing    <= 1'b0;
    end else begin
      // a result taken now is replaced below when a new one is loaded
      if (out_valid && out_ready && !(state == S_WRAP && last_r)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            closing <= 1'b0;
            if (seen_count == '0) begin
              parity <= 1'b0;
              state  <= S_WRAP;
            end else begin
              state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          if (yf0 == yf1) begin
            state <= S_NEXT;
          end else if (xf0 == xf1) begin
            parity <= parity ^ xf0;
            state  <= S_NEXT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          parity <= parity ^ cross_hit;
          state  <= S_NEXT;
        end
        S_NEXT: begin
          if (!closing && last_r) begin
            closing <= 1'b1;
            state   <= S_EDGE;
          end else begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (last_r) begin
            // result waits for a free output register
            if (!out_valid || out_ready) begin
              out_valid  <= 1'b1;
              seen_count <= '0;
              parity     <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            if (seen_count != ppc_pkg::SEEN_SAT) begin
              seen_count <= seen_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_vx <= vertex_x;
      cur_vy <= vertex_y;
      last_r <= last_vertex;
      if (seen_count == '0) begin
        held_point_x <= point_x;
        held_point_y <= point_y;
        first_vx     <= vertex_x;
        first_vy     <= vertex_y;
      end
    end
    if (state == S_EDGE) begin
      a_mag <= a_diff[DW-1] ? DW'(-a_diff) : DW'(a_diff);
      b_mag <= b_diff[DW-1] ? DW'(-b_diff) : DW'(b_diff);
      d_mag <= d_diff[DW-1] ? DW'(-d_diff) : DW'(d_diff);
      r_val <= r_diff;
      neg   <= a_diff[DW-1] ^ b_diff[DW-1] ^ d_diff[DW-1];
    end
    if (state == S_WRAP) begin
      prev_vx <= cur_vx;
      prev_vy <= cur_vy;
      if (last_r && (!out_valid || out_ready)) begin
        // fewer than three vertices when the count before this one is below two
        if (seen_count < ppc_pkg::SEEN_MIN_POLY) begin
          inside_res <= 1'b0;
          too_few    <= 1'b1;
        end else begin
          inside_res <= parity;
          too_few    <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: src/ppc_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on ppc_pkg (control and status structs).
module ppc_divider #(
  parameter int NUM_WIDTH = 34,
  parameter int DEN_WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ppc_pkg::ppc_div_ctrl_t   ctrl,
  input  logic [NUM_WIDTH-1:0]     dividend,
  input  logic [DEN_WIDTH-1:0]     divisor,
  output ppc_pkg::ppc_div_stat_t   stat,
  output logic [NUM_WIDTH-1:0]     quotient
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] quo;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH-1:0] den;
  logic [CNT_WIDTH-1:0] count;
  logic                 busy;
  logic                 done;

  logic [DEN_WIDTH:0]   shifted;
  logic [DEN_WIDTH:0]   diff;
  logic                 fits;
  logic [DEN_WIDTH-1:0] rem_next;

  // One trial subtraction per cycle
  assign shifted  = {rem, quo[NUM_WIDTH-1]};
  assign fits     = shifted >= {1'b0, den};
  assign diff     = shifted - {1'b0, den};
  assign rem_next = fits ? diff[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];

  // Control: busy while bits remain, done pulses after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= CNT_WIDTH'(NUM_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top, quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_WIDTH-2:0], fits};
      rem <= rem_next;
    end
  end

  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: tb/crossing_parity_checker.sv
// Checker for the point-in-polygon crossing block: watches both item channels,
// predicts each crossing verdict and compares it with what the block delivers.
// Depends on ppc_pkg for the vertex counter width and saturation value.
`timescale 1ns / 1ps

module crossing_parity_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          last_vertex,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          inside_res,
  input  logic                          too_few,
  output int                            errors,
  output int                            pending,
  output int                            n_results,
  output int                            n_inside,
  output int                            n_too_few
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic in_poly;
    logic few;
  } verdict_t;

  // Intercept quotients beyond this are treated as far off to one side
  localparam longint QUOT_LIMIT = longint'(1) << 34;

  // Predicted state of the block
  coord_t                         held_px, held_py;
  coord_t                         first_x, first_y;
  coord_t                         prev_x, prev_y;
  logic [ppc_pkg::SEEN_WIDTH-1:0] seen;
  logic                           parity;
  verdict_t                       verdict_q[$];

  // 1 if the edge (x0,y0)->(x1,y1) crosses the rightward ray from (px,py)
  function automatic logic edge_crosses(coord_t px, coord_t py, coord_t x0, coord_t y0,
                                        coord_t x1, coord_t y1);
    longint a, b, d, r, qm;
    logic   neg;
    // both ends on the same side of the point's y: no crossing
    if ((y0 >= py) == (y1 >= py)) return 1'b0;
    // both right (or both left) of the point: no intercept needed
    if ((x0 >= px) == (x1 >= px)) return x0 >= px;
    a = longint'(y1) - longint'(py);
    b = longint'(x0) - longint'(x1);
    d = longint'(y0) - longint'(y1);
    // magnitude quotient, truncated toward zero; sign applied separately
    qm = ((a < 0) ? -a : a) * ((b < 0) ? -b : b) / ((d < 0) ? -d : d);
    neg = ((a < 0) != (b < 0)) != (d < 0);
    r = longint'(x1) - longint'(px);
    if (qm > QUOT_LIMIT) return neg;
    return neg ? (r >= -qm) : (r >= qm);
  endfunction

  always @(posedge clk) begin : track
    verdict_t want;
    verdict_t next_verdict;
    if (rst) begin
      held_px = '0;
      held_py = '0;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      seen = '0;
      parity = 1'b0;
      verdict_q.delete();
      errors = 0;
      n_results = 0;
      n_inside = 0;
      n_too_few = 0;
    end else begin
      // compare a delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: inside_res=%0b too_few=%0b",
                   $time, inside_res, too_few);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (inside_res !== want.in_poly) begin
            $display("%0t: inside_res mismatch: expected %0b, got %0b",
                     $time, want.in_poly, inside_res);
            errors++;
          end
          if (too_few !== want.few) begin
            $display("%0t: too_few mismatch: expected %0b, got %0b",
                     $time, want.few, too_few);
            errors++;
          end
          n_results++;
          if (want.in_poly) n_inside++;
          if (want.few) n_too_few++;
        end
      end

      // step the prediction on each accepted vertex item
      if (in_valid && in_ready) begin
        if (seen == '0) begin
          // first vertex: latch the test point, start a new polygon
          held_px = point_x;
          held_py = point_y;
          first_x = vertex_x;
          first_y = vertex_y;
          parity = 1'b0;
        end else begin
          parity ^= edge_crosses(held_px, held_py, prev_x, prev_y, vertex_x, vertex_y);
        end
        prev_x = vertex_x;
        prev_y = vertex_y;
        if (seen < ppc_pkg::SEEN_SAT) seen++;

        if (last_vertex) begin
          // closing edge back to the first vertex
          parity ^= edge_crosses(held_px, held_py, vertex_x, vertex_y, first_x, first_y);
          if (seen < ppc_pkg::SEEN_SAT) begin
            next_verdict.in_poly = 1'b0;
            next_verdict.few = 1'b1;
          end else begin
            next_verdict.in_poly = parity;
            next_verdict.few = 1'b0;
          end
          verdict_q.push_back(next_verdict);
          seen = '0;
          parity = 1'b0;
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

FILE: tb/point_in_polygon_crossing_tb.sv
// Testbench top for point_in_polygon_crossing: clock, reset, vertex stimulus,
// result-side backpressure and the final verdict.
// Depends on ppc_pkg, the block under test and crossing_parity_checker.
`timescale 1ns / 1ps

module point_in_polygon_crossing_tb;

  localparam int          COORD_WIDTH  = 16;
  localparam int unsigned ITEMS        = 1050;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // coordinate distributions for random polygons
  typedef enum int {
    SPAN_TIGHT,
    SPAN_MID,
    SPAN_FULL,
    SPAN_EDGES
  } span_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t point_x = '0;
  coord_t point_y = '0;
  coord_t vertex_x = '0;
  coord_t vertex_y = '0;
  logic   last_vertex = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   inside_res;
  logic   too_few;

  int errors, pending, n_results, n_inside, n_too_few;
  int unsigned n_vertices = 0;
  int unsigned n_polygons = 0;
  int unsigned idle_pct = 20;
  bit hold_req = 1'b0;
  bit hold_issued = 1'b0;

  point_in_polygon_crossing #(
    .COORD_WIDTH(COORD_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_x(point_x),
    .point_y(point_y),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res),
    .too_few(too_few)
  );

  crossing_parity_checker #(
    .COORD_WIDTH(COORD_WIDTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_x(point_x),
    .point_y(point_y),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res),
    .too_few(too_few),
    .errors(errors),
    .pending(pending),
    .n_results(n_results),
    .n_inside(n_inside),
    .n_too_few(n_too_few)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic coord_t rand_coord(span_t span);
    case (span)
      SPAN_TIGHT: return coord_t'(int'($urandom_range(0, 40)) - 20);
      SPAN_MID:   return coord_t'(int'($urandom_range(0, 2000)) - 1000);
      SPAN_EDGES: begin
        case ($urandom_range(0, 6))
          0:       return coord_t'(-32768);
          1:       return coord_t'(-32767);
          2:       return coord_t'(-1);
          3:       return coord_t'(0);
          4:       return coord_t'(1);
          5:       return coord_t'(32766);
          default: return coord_t'(32767);
        endcase
      end
      default:    return coord_t'($urandom());
    endcase
  endfunction

  // offer one vertex item, with an optional idle burst first
  task automatic send_vertex(int px, int py, int vx, int vy, logic last);
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= coord_t'(px);
    point_y <= coord_t'(py);
    vertex_x <= coord_t'(vx);
    vertex_y <= coord_t'(vy);
    last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_vertices++;
    if (last) n_polygons++;
  endtask

  // random polygon; point fields after the first vertex are noise
  task automatic send_polygon(int unsigned count, span_t span);
    coord_t px, py;
    span_t  vspan;
    px = rand_coord(span);
    py = rand_coord(span);
    for (int unsigned i = 0; i < count; i++) begin
      vspan = ($urandom_range(0, 9) == 0) ? span_t'($urandom_range(0, 3)) : span;
      send_vertex((i == 0) ? int'(px) : int'(rand_coord(SPAN_FULL)),
                  (i == 0) ? int'(py) : int'(rand_coord(SPAN_FULL)),
                  int'(rand_coord(vspan)), int'(rand_coord(vspan)), i == count - 1);
    end
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned count;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single vertex marked last: too few at once
    send_vertex(5, 5, 5, 5, 1'b1);
    // two vertices: too few
    send_vertex(0, 0, -10, -10, 1'b0);
    send_vertex(7, 7, 10, 10, 1'b1);
    // small triangle around the origin, later point fields at extremes
    send_vertex(0, 0, -10, -10, 1'b0);
    send_vertex(-32768, 32767, 10, -10, 1'b0);
    send_vertex(32767, -32768, 0, 10, 1'b1);
    // full-range triangle, intercepts with the largest products
    send_vertex(0, 0, -32768, -32768, 1'b0);
    send_vertex(0, 0, 32767, -32768, 1'b0);
    send_vertex(0, 0, 0, 32767, 1'b1);
    // point at the far left edge of the range
    send_vertex(-32768, 0, 32767, -32768, 1'b0);
    send_vertex(0, 0, 32767, 32767, 1'b0);
    send_vertex(0, 0, -32768, -1, 1'b1);
    // point on the left side of a square
    send_vertex(0, 0, 0, -5, 1'b0);
    send_vertex(0, 0, 5, -5, 1'b0);
    send_vertex(0, 0, 5, 5, 1'b0);
    send_vertex(0, 0, 0, 5, 1'b1);
    // concave pentagon with the point on a vertex; count saturates
    send_vertex(2, 1, 0, 0, 1'b0);
    send_vertex(2, 1, 4, 0, 1'b0);
    send_vertex(2, 1, 4, 4, 1'b0);
    send_vertex(2, 1, 2, 1, 1'b0);
    send_vertex(2, 1, 0, 4, 1'b1);

    // random polygons, idling varied by phase
    while (n_vertices < ITEMS) begin
      if (!hold_issued && n_vertices >= 250) begin
        hold_req = 1'b1;
        hold_issued = 1'b1;
      end
      if ((n_vertices >= 450 && n_vertices < 650) || n_vertices >= 900) idle_pct = 0;
      else if (n_vertices >= 650) idle_pct = 35;
      else idle_pct = 20;
      case ($urandom_range(0, 19))
        0:       count = 1;
        1:       count = 2;
        2, 3:    count = $urandom_range(9, 14);
        default: count = $urandom_range(3, 8);
      endcase
      send_polygon(count, span_t'($urandom_range(0, 3)));
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let any stray activity show up
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d vertex items in %0d polygons; %0d verdicts checked",
             n_vertices, n_polygons, n_results);
    $display("%0d inside, %0d too few, with stalls on both sides and one long output hold",
             n_inside, n_too_few);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
